/* rtl/core/stmu_pkg.sv */
`default_nettype none

package stmu_pkg;

	localparam int TILE_LOG2      = 6;
	localparam int FRACTION_BITS  = 16;
	localparam int COLUMN_BITS    = 10;
	localparam int ADDR_BITS      = 2 * TILE_LOG2;
	localparam int QUEUE_DEPTH    = 4;
	localparam int QUEUE_PTR_BITS = $clog2(QUEUE_DEPTH);

	localparam logic [1:0] ACT_LOAD_TEXEL = 2'd0;
	localparam logic [1:0] ACT_LOAD_LIGHT = 2'd1;
	localparam logic [1:0] ACT_START      = 2'd2;
	localparam logic [1:0] ACT_STEP       = 2'd3;

	typedef struct packed {
		logic [1:0]             action;
		logic [11:0]            load_index;
		logic [7:0]             load_data;
		logic [9:0]             span_row;
		logic [COLUMN_BITS-1:0] first_column;
		logic [COLUMN_BITS-1:0] final_column;
		logic signed [31:0]     u_start;
		logic signed [31:0]     v_start;
		logic signed [31:0]     u_increment;
		logic signed [31:0]     v_increment;
		logic                   low_detail;
	} in_item_t;

	typedef struct packed {
		logic [COLUMN_BITS:0]   pixel_column;
		logic [9:0]             pixel_row;
		logic [7:0]             pixel_colour;
		logic                   span_last;
	} out_item_t;

	// queue entry: a store write or one pixel to look up
	typedef struct packed {
		logic [1:0]             kind;
		logic [ADDR_BITS-1:0]   addr;
		logic [7:0]             data;
		logic [COLUMN_BITS-1:0] column;
		logic [9:0]             row;
		logic                   dbl;
		logic                   last;
	} cmd_t;

endpackage

`default_nettype wire

/* rtl/core/span_texture_mapper_unit.sv */
// Channel  Handshake              Payload
// in       in_valid / in_ready    stmu_pkg::in_item_t   load, start or step
// out      out_valid / out_ready  stmu_pkg::out_item_t  one pixel
//
// One item per cycle enters while the queue is not full; a step's pixel passes
// through the queue, the texel read, the colormap read and the output register.
// Low detail gives two pixels per step; the output register holds such a step until both are taken.
// Reset clears the span and the pipe valid bits; the stores are not cleared.
// A held output stalls the back pipe; the four-entry queue lets the front run on.
`default_nettype none

module span_texture_mapper_unit (
	input  wire logic           clk,
	input  wire logic           arst_n,
	input  wire logic           in_valid,
	output logic                in_ready,
	input  stmu_pkg::in_item_t  in_item,
	output logic                out_valid,
	input  wire logic           out_ready,
	output stmu_pkg::out_item_t out_item
);
	import stmu_pkg::*;

	logic push;
	cmd_t push_cmd;
	logic pop;
	cmd_t head;
	logic head_valid;
	logic full;

	stmu_front u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.in_item  (in_item),
		.full     (full),
		.push     (push),
		.push_cmd (push_cmd)
	);

	stmu_queue u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.push_cmd   (push_cmd),
		.pop        (pop),
		.head       (head),
		.head_valid (head_valid),
		.full       (full)
	);

	stmu_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.head       (head),
		.head_valid (head_valid),
		.pop        (pop),
		.out_valid  (out_valid),
		.out_ready  (out_ready),
		.out_item   (out_item)
	);

endmodule

`default_nettype wire

/* rtl/core/stmu_front.sv */
`default_nettype none

module stmu_front (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              in_valid,
	output logic                   in_ready,
	input  stmu_pkg::in_item_t     in_item,
	input  wire logic              full,
	output logic                   push,
	output stmu_pkg::cmd_t         push_cmd
);
	import stmu_pkg::*;

	logic                   span_active_q;
	logic [31:0]            u_q;
	logic [31:0]            v_q;
	logic [31:0]            u_step_q;
	logic [31:0]            v_step_q;
	logic [COLUMN_BITS-1:0] cur_col_q;
	logic [COLUMN_BITS-1:0] end_col_q;
	logic [9:0]             row_q;
	logic                   dbl_q;
	logic                   acc;
	logic                   last;

	assign in_ready = !full;
	assign acc      = in_valid && in_ready;
	assign last     = cur_col_q == end_col_q;

	always_comb begin
		push_cmd.kind   = in_item.action;
		push_cmd.addr   = ADDR_BITS'(in_item.load_index);
		push_cmd.data   = in_item.load_data;
		push_cmd.column = cur_col_q;
		push_cmd.row    = row_q;
		push_cmd.dbl    = dbl_q;
		push_cmd.last   = last;
		push            = 1'b0;
		case (in_item.action)
			ACT_LOAD_TEXEL, ACT_LOAD_LIGHT: begin
				push = acc;
			end
			ACT_STEP: begin
				push          = acc && span_active_q;
				push_cmd.addr = {v_q[FRACTION_BITS+TILE_LOG2-1:FRACTION_BITS],
				                 u_q[FRACTION_BITS+TILE_LOG2-1:FRACTION_BITS]};
			end
			default: begin
				push = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			span_active_q <= 1'b0;
		end else if (acc && in_item.action == ACT_START) begin
			span_active_q <= in_item.final_column >= in_item.first_column;
		end else if (acc && in_item.action == ACT_STEP && span_active_q && last) begin
			span_active_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (acc && in_item.action == ACT_START) begin
			u_q       <= in_item.u_start;
			v_q       <= in_item.v_start;
			u_step_q  <= in_item.u_increment;
			v_step_q  <= in_item.v_increment;
			cur_col_q <= in_item.first_column;
			end_col_q <= in_item.final_column;
			row_q     <= in_item.span_row;
			dbl_q     <= in_item.low_detail;
		end else if (acc && in_item.action == ACT_STEP && span_active_q) begin
			u_q       <= u_q + u_step_q;
			v_q       <= v_q + v_step_q;
			cur_col_q <= cur_col_q + 1'b1;
		end
	end

endmodule

`default_nettype wire

/* rtl/core/stmu_queue.sv */
`default_nettype none

module stmu_queue (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          push,
	input  stmu_pkg::cmd_t     push_cmd,
	input  wire logic          pop,
	output stmu_pkg::cmd_t     head,
	output logic               head_valid,
	output logic               full
);
	import stmu_pkg::*;

	cmd_t                    entry_q [QUEUE_DEPTH];
	logic [QUEUE_PTR_BITS-1:0] wr_ptr_q;
	logic [QUEUE_PTR_BITS-1:0] rd_ptr_q;
	logic [QUEUE_PTR_BITS:0]   count_q;

	assign head       = entry_q[rd_ptr_q];
	assign head_valid = count_q != '0;
	assign full       = count_q == (QUEUE_PTR_BITS+1)'(QUEUE_DEPTH);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push)
				wr_ptr_q <= wr_ptr_q + 1'b1;
			if (pop)
				rd_ptr_q <= rd_ptr_q + 1'b1;
			if (push && !pop)
				count_q <= count_q + 1'b1;
			else if (pop && !push)
				count_q <= count_q - 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (push)
			entry_q[wr_ptr_q] <= push_cmd;
	end

endmodule

`default_nettype wire

/* rtl/core/stmu_back.sv */
`default_nettype none

module stmu_back (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  stmu_pkg::cmd_t     head,
	input  wire logic          head_valid,
	output logic               pop,
	output logic               out_valid,
	input  wire logic          out_ready,
	output stmu_pkg::out_item_t out_item
);
	import stmu_pkg::*;

	localparam int TEXEL_DEPTH = 1 << ADDR_BITS;

	logic [7:0] texel_mem [TEXEL_DEPTH];
	logic [7:0] light_mem [256];

	logic       en;
	logic       valid_s1;
	cmd_t       cmd_s1;
	logic [7:0] texel_s1;
	logic       valid_s2;
	cmd_t       cmd_s2;
	logic [7:0] colour_s2;
	logic       out_valid_q;
	logic       phase_q;
	cmd_t       out_cmd_q;
	logic [7:0] out_colour_q;

	// whole pipe holds while the output item still waits
	assign en  = !out_valid_q || (out_ready && (!out_cmd_q.dbl || phase_q));
	assign pop = en && head_valid;

	always_ff @(posedge clk) begin
		if (pop) begin
			if (head.kind == ACT_LOAD_TEXEL)
				texel_mem[head.addr] <= head.data;
			texel_s1 <= texel_mem[head.addr];
			cmd_s1   <= head;
		end
	end

	always_ff @(posedge clk) begin
		if (en && valid_s1) begin
			if (cmd_s1.kind == ACT_LOAD_LIGHT)
				light_mem[cmd_s1.addr[7:0]] <= cmd_s1.data;
			colour_s2 <= light_mem[texel_s1];
			cmd_s2    <= cmd_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (en && valid_s2) begin
			out_cmd_q    <= cmd_s2;
			out_colour_q <= colour_s2;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1    <= 1'b0;
			valid_s2    <= 1'b0;
			out_valid_q <= 1'b0;
			phase_q     <= 1'b0;
		end else if (en) begin
			valid_s1    <= head_valid;
			valid_s2    <= valid_s1;
			out_valid_q <= valid_s2 && cmd_s2.kind == ACT_STEP;
			phase_q     <= 1'b0;
		end else if (out_valid_q && out_ready) begin
			phase_q <= 1'b1;
		end
	end

	assign out_valid = out_valid_q;

	always_comb begin
		out_item.pixel_column = out_cmd_q.dbl ? {out_cmd_q.column, phase_q}
		                                      : {1'b0, out_cmd_q.column};
		out_item.pixel_row    = out_cmd_q.row;
		out_item.pixel_colour = out_colour_q;
		out_item.span_last    = out_cmd_q.last && (!out_cmd_q.dbl || phase_q);
	end

endmodule

`default_nettype wire

/* rtl/core/stmu_checker.sv */
`default_nettype none

module stmu_checker (
	input  wire logic           clk,
	input  wire logic           arst_n,
	input  wire logic           in_valid,
	input  wire logic           in_ready,
	input  stmu_pkg::in_item_t  in_item,
	input  wire logic           out_valid,
	input  wire logic           out_ready,
	input  stmu_pkg::out_item_t out_item
);
	import stmu_pkg::*;

	a_in_hold: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_ready |=> in_valid && $stable(in_item))
		else $error("input item dropped or changed while stalled");

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(out_item))
		else $error("output item dropped or changed while stalled");

	a_reset_idle: assert property (@(posedge clk)
		!arst_n |=> !out_valid)
		else $error("output valid during reset");

	// the queue fills only behind a held output item
	a_full_needs_stall: assert property (@(posedge clk) disable iff (!arst_n)
		!in_ready |-> out_valid)
		else $error("input stalled with no output pending");

endmodule

bind span_texture_mapper_unit stmu_checker u_stmu_checker (.*);

`default_nettype wire

/* bench/span_texture_mapper_unit_tb.sv */
`default_nettype none

module span_texture_mapper_unit_tb;
	import stmu_pkg::*;

	localparam int RANDOM_ITEMS = 1950;
	localparam int HOLD_CYCLES  = 400;
	localparam int DRAIN_CYCLES = 30;
	localparam int CYCLE_LIMIT  = 400000;

	typedef enum logic [1:0] {RX_ALWAYS, RX_PATTERN, RX_RANDOM} rx_mode_t;

	class pixel_scoreboard;
		logic [7:0]  texels [4096];
		bit          texel_known [4096];
		logic [7:0]  shades [256];
		bit          shade_known [256];
		logic [31:0] u_pos, v_pos, u_inc, v_inc;
		logic [9:0]  col, end_col, row;
		bit          dbl, active;
		out_item_t   pixels_due [$];
		int          mismatches;

		function new();
			u_pos = '0;
			v_pos = '0;
			u_inc = '0;
			v_inc = '0;
			col = '0;
			end_col = '0;
			row = '0;
			dbl = 1'b0;
			active = 1'b0;
			mismatches = 0;
		endfunction

		function logic [ADDR_BITS-1:0] texel_slot();
			return {v_pos[FRACTION_BITS +: TILE_LOG2], u_pos[FRACTION_BITS +: TILE_LOG2]};
		endfunction

		function void note_input(in_item_t it);
			logic [ADDR_BITS-1:0] a;
			bit                   last_px;
			out_item_t            px;
			case (it.action)
				ACT_LOAD_TEXEL: begin
					texels[it.load_index] = it.load_data;
					texel_known[it.load_index] = 1'b1;
				end
				ACT_LOAD_LIGHT: begin
					shades[it.load_index[7:0]] = it.load_data;
					shade_known[it.load_index[7:0]] = 1'b1;
				end
				ACT_START: begin
					row = it.span_row;
					col = it.first_column;
					end_col = it.final_column;
					u_pos = it.u_start;
					v_pos = it.v_start;
					u_inc = it.u_increment;
					v_inc = it.v_increment;
					dbl = it.low_detail;
					active = it.final_column >= it.first_column;
				end
				default: begin
					if (active) begin
						a = texel_slot();
						last_px = (col == end_col);
						px.pixel_row = row;
						px.pixel_colour = shades[texels[a]];
						if (dbl) begin
							px.pixel_column = {col, 1'b0};
							px.span_last = 1'b0;
							pixels_due.push_back(px);
							px.pixel_column = {col, 1'b1};
						end else begin
							px.pixel_column = {1'b0, col};
						end
						px.span_last = last_px;
						pixels_due.push_back(px);
						u_pos += u_inc;
						v_pos += v_inc;
						col += 10'd1;
						if (last_px)
							active = 1'b0;
					end
				end
			endcase
		endfunction

		function void check_result(out_item_t got);
			out_item_t want;
			bit        bad;
			if (pixels_due.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("unexpected pixel: col %0d row %0d colour %0d last %0d",
						got.pixel_column, got.pixel_row, got.pixel_colour, got.span_last);
				return;
			end
			want = pixels_due.pop_front();
			bad = (got.pixel_column !== want.pixel_column) ||
				(got.pixel_row !== want.pixel_row) ||
				(got.pixel_colour !== want.pixel_colour) ||
				(got.span_last !== want.span_last);
			if (bad) begin
				mismatches++;
				if (mismatches <= 10)
					$display({"pixel mismatch: want col %0d row %0d colour %0d last %0d, ",
						"got col %0d row %0d colour %0d last %0d"},
						want.pixel_column, want.pixel_row, want.pixel_colour, want.span_last,
						got.pixel_column, got.pixel_row, got.pixel_colour, got.span_last);
			end
		endfunction
	endclass

	logic      clk;
	logic      arst_n;
	logic      in_valid;
	logic      in_ready;
	in_item_t  in_item;
	logic      out_valid;
	logic      out_ready;
	out_item_t out_item;

	pixel_scoreboard sb;
	int       cycle_count = 0;
	int       counted = 0;
	int       burst_left = 0;
	bit       hold_request = 1'b0;
	rx_mode_t ready_mode = RX_ALWAYS;
	int       phase_left = 0;
	logic [7:0] ready_mask = 8'hFF;

	span_texture_mapper_unit u_dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.in_item  (in_item),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.out_item (out_item)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (arst_n && out_valid && out_ready)
			sb.check_result(out_item);
	end

	initial begin
		wait (cycle_count >= CYCLE_LIMIT);
		$display("Regression FAIL");
		$finish;
	end

	// receiver: changing stall patterns, one long hold-off on request
	initial begin
		out_ready = 1'b0;
		@(posedge arst_n);
		forever begin
			@(negedge clk);
			if (hold_request) begin
				hold_request = 1'b0;
				out_ready = 1'b0;
				repeat (HOLD_CYCLES) @(negedge clk);
			end
			if (phase_left == 0) begin
				ready_mode = rx_mode_t'($urandom_range(0, 2));
				ready_mask = 8'($urandom) | 8'h01;
				phase_left = $urandom_range(50, 300);
			end
			phase_left--;
			case (ready_mode)
				RX_ALWAYS: out_ready = 1'b1;
				RX_PATTERN: begin
					out_ready = ready_mask[0];
					ready_mask = {ready_mask[0], ready_mask[7:1]};
				end
				default: out_ready = ($urandom_range(0, 3) != 0);
			endcase
		end
	end

	function automatic in_item_t noise_item();
		in_item_t it;
		it.action = 2'($urandom);
		it.load_index = 12'($urandom);
		it.load_data = 8'($urandom);
		it.span_row = 10'($urandom);
		it.first_column = 10'($urandom);
		it.final_column = 10'($urandom);
		it.u_start = $urandom;
		it.v_start = $urandom;
		it.u_increment = $urandom;
		it.v_increment = $urandom;
		it.low_detail = 1'($urandom);
		return it;
	endfunction

	// called at a falling edge; returns at a falling edge
	task automatic send_item(input in_item_t it);
		bit counts;
		in_item = it;
		in_valid = 1'b1;
		@(posedge clk);
		while (!in_ready)
			@(posedge clk);
		counts = (it.action != ACT_STEP) || sb.active;
		sb.note_input(it);
		if (counts)
			counted++;
		@(negedge clk);
		if (burst_left > 0)
			burst_left--;
		if (burst_left == 0) begin
			in_valid = 1'b0;
			repeat ($urandom_range(1, 6)) @(negedge clk);
			burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(40, 120) :
				$urandom_range(1, 12);
		end
	endtask

	task automatic send_load(input logic [1:0] act, input logic [11:0] idx,
		input logic [7:0] data);
		in_item_t it;
		it = noise_item();
		it.action = act;
		it.load_index = idx;
		it.load_data = data;
		send_item(it);
	endtask

	task automatic send_start(input logic [9:0] row, input logic [9:0] first_col,
		input logic [9:0] last_col, input logic [31:0] u0, input logic [31:0] v0,
		input logic [31:0] du, input logic [31:0] dv, input logic ld);
		in_item_t it;
		it = noise_item();
		it.action = ACT_START;
		it.span_row = row;
		it.first_column = first_col;
		it.final_column = last_col;
		it.u_start = u0;
		it.v_start = v0;
		it.u_increment = du;
		it.v_increment = dv;
		it.low_detail = ld;
		send_item(it);
	endtask

	// fills any store entry the next pixel would read before stepping
	task automatic send_step();
		in_item_t             it;
		logic [ADDR_BITS-1:0] a;
		logic [11:0]          idx;
		if (sb.active) begin
			a = sb.texel_slot();
			if (!sb.texel_known[a])
				send_load(ACT_LOAD_TEXEL, a, 8'($urandom));
			idx = 12'($urandom);
			idx[7:0] = sb.texels[a];
			if (!sb.shade_known[idx[7:0]])
				send_load(ACT_LOAD_LIGHT, idx, 8'($urandom));
		end
		it = noise_item();
		it.action = ACT_STEP;
		send_item(it);
	endtask

	function automatic logic [31:0] rand_increment();
		int small_inc;
		small_inc = $urandom_range(0, 1 << 19);
		if ($urandom_range(0, 3) == 0)
			return $urandom;
		return small_inc - (1 << 18);
	endfunction

	initial begin
		int first_col, last_col, len, steps, pick;
		sb = new();
		in_valid = 1'b0;
		in_item = '0;
		arst_n = 1'b0;
		repeat (9) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// directed: extremes, every action, each corner
		send_step();
		send_load(ACT_LOAD_TEXEL, 12'hFFF, 8'hFF);
		send_load(ACT_LOAD_TEXEL, 12'h000, 8'h00);
		send_load(ACT_LOAD_LIGHT, 12'h0FF, 8'h00);
		send_load(ACT_LOAD_LIGHT, 12'hF00, 8'hFF);
		send_start(10'h3FF, 10'h3FF, 10'h3FF, 32'h003F_0000, 32'h003F_FFFF, '0, '0, 1'b0);
		send_step();
		send_step();
		send_start(10'h000, 10'h3FF, 10'h3FF, '0, '0, '0, '0, 1'b1);
		send_step();
		send_start(10'd5, 10'd5, 10'd4, '0, '0, '0, '0, 1'b0);
		send_step();
		send_start(10'd512, 10'd0, 10'd2, 32'h7FFF_FFFF, 32'h8000_0000, 32'h0000_0001,
			32'hFFFF_FFFF, 1'b0);
		repeat (3) send_step();
		send_start(10'd300, 10'd100, 10'd103, 32'h0012_8000, 32'hFFF0_0000, 32'h0001_8000,
			32'hFFFF_4000, 1'b1);
		send_step();
		send_load(ACT_LOAD_TEXEL, 12'($urandom), 8'($urandom));
		send_step();
		send_start(10'd7, 10'd0, 10'd0, 32'h8000_0000, 32'h7FFF_0000, 32'h8000_0000,
			32'h8000_0000, 1'b0);
		send_step();
		send_step();

		// random: mostly well-formed spans, some noise
		counted = 0;
		hold_request = 1'b1;
		while (counted < RANDOM_ITEMS) begin
			pick = $urandom_range(0, 9);
			if (pick < 7) begin
				len = ($urandom_range(0, 19) == 0) ? $urandom_range(20, 80) :
					$urandom_range(1, 10);
				first_col = $urandom_range(0, 1023);
				last_col = (first_col + len - 1 > 1023) ? 1023 : first_col + len - 1;
				len = last_col - first_col + 1;
				if (pick == 6 && first_col > 0 && $urandom_range(0, 1) == 0) begin
					last_col = $urandom_range(0, first_col - 1);
					len = 0;
				end
				steps = len + $urandom_range(0, 2);
				if (len > 1 && $urandom_range(0, 7) == 0)
					steps = $urandom_range(0, len - 1);
				send_start(10'($urandom), 10'(first_col), 10'(last_col), $urandom, $urandom,
					rand_increment(), rand_increment(), 1'($urandom));
				repeat (steps) begin
					if ($urandom_range(0, 9) == 0)
						send_load(2'($urandom_range(0, 1)), 12'($urandom), 8'($urandom));
					send_step();
				end
			end else if (pick < 9) begin
				repeat ($urandom_range(1, 4))
					send_load(2'($urandom_range(0, 1)), 12'($urandom), 8'($urandom));
			end else begin
				send_step();
			end
		end

		in_valid = 1'b0;
		while (sb.pixels_due.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (sb.mismatches == 0 && sb.pixels_due.size() == 0)
			$display("Regression PASS");
		else
			$display("Regression FAIL");
		$finish;
	end

endmodule

`default_nettype wire
